// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define AET_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define AET_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define AET_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define AET_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== sv/aet_pkg.sv =====
package aet_pkg;

   // Input modes
   localparam logic [1:0] MODE_CHAR = 2'd0;
   localparam logic [1:0] MODE_EOL  = 2'd1;
   localparam logic [1:0] MODE_EOI  = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_NUMBER = 2'd0;
   localparam logic [1:0] KIND_OPER   = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   // Character codes
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] line_no;
      logic [15:0] column_no;
      logic [15:0] token_length;
      logic [7:0]  op_char;
      logic        last_of_run;
   } rsp_type;

endpackage

// ===== sv/aet_stream_if.sv =====
// Valid/ready channel carrying one payload item per handshake.
interface aet_stream_if #(
   parameter type payload_type = logic [0:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/arith_expr_tokenizer.sv =====
// Arithmetic expression tokenizer. Characters enter on req_if (mode 0 with a
// byte, mode 1 end of line, mode 2 end of input) and tokens leave on rsp_if:
// operators ( ) + - * /, numbers with at most one interior dot, END, or one
// syntax error after which the block drops all input until reset. An item is
// taken every cycle while the result buffer has room; it passes the input
// register, then the token logic writes a two-entry result buffer. An item
// that yields two results (a number closed by an operator or by end of
// input) needs the result buffer empty, so it holds the input register until
// the buffer drains, and the next item that yields a result then waits for a
// free buffer entry. Line and column counts are POSITION_BITS wide and
// saturate; the output fields carry their low 16 bits. No clearing pass after
// reset.
`include "assert_macros.svh"

module arith_expr_tokenizer #(
   parameter int POSITION_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   aet_stream_if.sink    req_if,
   aet_stream_if.source  rsp_if
);

   localparam int P = POSITION_BITS;

   // Input register
   logic              in_valid_ff;
   aet_pkg::req_type  in_item_ff;

   // Tokenizer state
   logic [P-1:0] line_count_ff, line_count_in;
   logic [P-1:0] column_count_ff, column_count_in;
   logic         number_active_ff, number_active_in;
   logic [P-1:0] number_start_ff, number_start_in;
   logic         number_has_dot_ff, number_has_dot_in;
   logic         dot_pending_ff, dot_pending_in;
   logic         dot_misplaced_ff, dot_misplaced_in;
   logic         halted_ff, halted_in;

   // Result buffer, slot0 is the head
   aet_pkg::rsp_type slot0_ff, slot0_in;
   aet_pkg::rsp_type slot1_ff, slot1_in;
   logic [1:0]       count_ff, count_in;

   // Step logic signals
   logic [P-1:0]     here;
   logic             is_digit;
   logic             is_oper;
   logic             is_space;
   logic [P:0]       num_len;
   logic [P+16:0]    num_len_ext;
   aet_pkg::rsp_type num_tok;
   aet_pkg::rsp_type res0, res1;
   logic [1:0]       n_res;
   logic             fits;
   logic             fire;
   logic             pop;
   logic [1:0]       push_n;

   function automatic logic [P-1:0] sat_inc(input logic [P-1:0] v);
      return (v == {P{1'b1}}) ? v : v + {{(P-1){1'b0}}, 1'b1};
   endfunction

   function automatic logic [15:0] low16(input logic [P-1:0] v);
      logic [P+15:0] ext;
      ext = {16'd0, v};
      return ext[15:0];
   endfunction

   // Character classes and the number token that a flush would emit
   always_comb begin
      here     = sat_inc(column_count_ff);
      is_digit = (in_item_ff.mode == aet_pkg::MODE_CHAR) &&
                 (in_item_ff.char_code inside {[aet_pkg::CH_ZERO:aet_pkg::CH_NINE]});
      is_oper  = in_item_ff.char_code inside {aet_pkg::CH_LPAREN, aet_pkg::CH_RPAREN,
                                              aet_pkg::CH_PLUS, aet_pkg::CH_MINUS,
                                              aet_pkg::CH_STAR, aet_pkg::CH_SLASH};
      is_space = in_item_ff.char_code inside {[aet_pkg::CH_TAB:aet_pkg::CH_CR],
                                              aet_pkg::CH_SPACE};
      num_len  = {1'b0, column_count_ff} - {1'b0, number_start_ff} +
                 {{P{1'b0}}, 1'b1};
      num_len_ext = {16'd0, num_len};
      num_tok.kind         = aet_pkg::KIND_NUMBER;
      num_tok.line_no      = low16(line_count_ff);
      num_tok.column_no    = low16(number_start_ff);
      num_tok.token_length = num_len_ext[15:0];
      num_tok.op_char      = 8'd0;
      num_tok.last_of_run  = 1'b0;
   end

   // One tokenizer step for the item in the input register
   always_comb begin
      line_count_in     = line_count_ff;
      column_count_in   = column_count_ff;
      number_active_in  = number_active_ff;
      number_start_in   = number_start_ff;
      number_has_dot_in = number_has_dot_ff;
      dot_pending_in    = dot_pending_ff;
      dot_misplaced_in  = dot_misplaced_ff;
      halted_in         = halted_ff;
      res0  = '0;
      res1  = '0;
      n_res = 2'd0;

      if (!halted_ff && in_item_ff.mode != aet_pkg::MODE_NONE) begin
         if (dot_pending_ff && (!is_digit || dot_misplaced_ff)) begin
            // dot not followed by a digit, or a dot where none may stand
            res0.kind      = aet_pkg::KIND_ERROR;
            res0.line_no   = low16(line_count_ff);
            res0.column_no = is_digit ? low16(column_count_ff) : low16(here);
            n_res          = 2'd1;
            halted_in      = 1'b1;
            dot_pending_in   = 1'b0;
            dot_misplaced_in = 1'b0;
         end else begin
            dot_pending_in   = 1'b0;
            dot_misplaced_in = 1'b0;
            case (in_item_ff.mode)
               aet_pkg::MODE_CHAR: begin
                  if (is_oper) begin
                     if (number_active_ff) begin
                        res0  = num_tok;
                        n_res = 2'd1;
                     end
                     number_active_in  = 1'b0;
                     number_has_dot_in = 1'b0;
                     if (number_active_ff) begin
                        res1.kind         = aet_pkg::KIND_OPER;
                        res1.line_no      = low16(line_count_ff);
                        res1.column_no    = low16(here);
                        res1.token_length = 16'd1;
                        res1.op_char      = in_item_ff.char_code;
                        n_res             = 2'd2;
                     end else begin
                        res0.kind         = aet_pkg::KIND_OPER;
                        res0.line_no      = low16(line_count_ff);
                        res0.column_no    = low16(here);
                        res0.token_length = 16'd1;
                        res0.op_char      = in_item_ff.char_code;
                        n_res             = 2'd1;
                     end
                     column_count_in = here;
                  end else if (is_space) begin
                     if (number_active_ff) begin
                        res0  = num_tok;
                        n_res = 2'd1;
                     end
                     number_active_in  = 1'b0;
                     number_has_dot_in = 1'b0;
                     column_count_in   = here;
                  end else if (in_item_ff.char_code == aet_pkg::CH_DOT) begin
                     dot_misplaced_in = !number_active_ff || number_has_dot_ff;
                     if (number_active_ff && !number_has_dot_ff) begin
                        number_has_dot_in = 1'b1;
                     end
                     dot_pending_in  = 1'b1;
                     column_count_in = here;
                  end else if (is_digit) begin
                     if (!number_active_ff) begin
                        number_active_in  = 1'b1;
                        number_start_in   = here;
                        number_has_dot_in = 1'b0;
                     end
                     column_count_in = here;
                  end else begin
                     // bad character; an open number is dropped
                     res0.kind      = aet_pkg::KIND_ERROR;
                     res0.line_no   = low16(line_count_ff);
                     res0.column_no = low16(here);
                     n_res          = 2'd1;
                     halted_in      = 1'b1;
                  end
               end
               aet_pkg::MODE_EOL: begin
                  if (number_active_ff) begin
                     res0  = num_tok;
                     n_res = 2'd1;
                  end
                  number_active_in  = 1'b0;
                  number_has_dot_in = 1'b0;
                  line_count_in     = sat_inc(line_count_ff);
                  column_count_in   = '0;
               end
               aet_pkg::MODE_EOI: begin
                  if (number_active_ff) begin
                     res0            = num_tok;
                     res1.kind       = aet_pkg::KIND_END;
                     res1.line_no    = low16(line_count_ff);
                     res1.column_no  = low16(here);
                     n_res           = 2'd2;
                  end else begin
                     res0.kind       = aet_pkg::KIND_END;
                     res0.line_no    = low16(line_count_ff);
                     res0.column_no  = low16(here);
                     n_res           = 2'd1;
                  end
                  // back to the reset state
                  line_count_in     = {{(P-1){1'b0}}, 1'b1};
                  column_count_in   = '0;
                  number_active_in  = 1'b0;
                  number_start_in   = '0;
                  number_has_dot_in = 1'b0;
                  halted_in         = 1'b0;
               end
               default: begin
               end
            endcase
         end
      end

      // mark the final result of the item
      if (n_res == 2'd2) begin
         res1.last_of_run = 1'b1;
      end else if (n_res == 2'd1) begin
         res0.last_of_run = 1'b1;
      end
   end

   // Step only when the result buffer has room without counting a pop
   always_comb begin
      fits = (n_res == 2'd0) || (count_ff == 2'd0) ||
             ((n_res == 2'd1) && (count_ff != 2'd2));
      fire   = in_valid_ff && fits;
      pop    = rsp_if.valid && rsp_if.ready;
      push_n = fire ? n_res : 2'd0;
   end

   assign req_if.ready   = !in_valid_ff || fire;
   assign rsp_if.valid   = (count_ff != 2'd0);
   assign rsp_if.payload = slot0_ff;

   // Result buffer update: pop the head, then append
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
      if (push_n != 2'd0) begin
         if (count_in == 2'd0) begin
            slot0_in = res0;
            slot1_in = res1;
         end else begin
            slot1_in = res0;
         end
      end
      count_in = count_in + push_n;
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.valid && req_if.ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
      if (req_if.valid && req_if.ready) begin
         in_item_ff <= req_if.payload;
      end
   end

   // Tokenizer state
   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff     <= {{(P-1){1'b0}}, 1'b1};
         column_count_ff   <= '0;
         number_active_ff  <= 1'b0;
         number_start_ff   <= '0;
         number_has_dot_ff <= 1'b0;
         dot_pending_ff    <= 1'b0;
         dot_misplaced_ff  <= 1'b0;
         halted_ff         <= 1'b0;
      end else if (fire) begin
         line_count_ff     <= line_count_in;
         column_count_ff   <= column_count_in;
         number_active_ff  <= number_active_in;
         number_start_ff   <= number_start_in;
         number_has_dot_ff <= number_has_dot_in;
         dot_pending_ff    <= dot_pending_in;
         dot_misplaced_ff  <= dot_misplaced_in;
         halted_ff         <= halted_in;
      end
   end

   // Result buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // Checks
   `AET_ASSERT_IMP(a_buffer_bound, clock, reset, 1'b1, count_ff != 2'd3, "result buffer overrun")
   `AET_ASSERT_NXT(a_error_halts, clock, reset, fire && (n_res == 2'd1) && (res0.kind == aet_pkg::KIND_ERROR), halted_ff, "error did not halt")
   `AET_ASSERT_NXT(a_halt_sticks, clock, reset, halted_ff, halted_ff && (push_n == 2'd0), "halt released or result after halt")

endmodule
